>>> sv/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared constants, item types and codes of the top-k minimum heap selector.
// ----------------------------------------------------------------------------
package tkh_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int K_W         = $clog2(MAX_ENTRIES + 1);
  localparam int CH_W        = IDX_W + 2;
  localparam int CFG_W       = 5;

  localparam logic [CFG_W-1:0] K_RESET     = 5'd10;
  localparam logic [31:0]      EMPTY_SCORE = 32'hFFFF_FFFF;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  typedef struct packed {
    logic [31:0] score;
    logic [63:0] head;
    logic [31:0] tail;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] id_head;
    logic [31:0] id_tail;
    logic [31:0] score;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [63:0] entry_head;
    logic [31:0] entry_tail;
    logic        accepted;
    logic        last;
  } out_item_t;

  // decision of the child compare unit for one heap level
  typedef struct packed {
    logic move;
    logic take_right;
  } cmp_sel_t;

endpackage

>>> sv/tkh_ifs.sv
// ----------------------------------------------------------------------------
// tkh channel interfaces
// Valid/ready channels for candidate items, result items and the K register.
// ----------------------------------------------------------------------------
interface tkh_in_if;
  import tkh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tkh_out_if;
  import tkh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface tkh_cfg_if;
  import tkh_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/tkh_store.sv
// ----------------------------------------------------------------------------
// tkh_store
// Heap entry memory: one write port, two registered read ports, valid bits
// so that a cleared or never written entry reads as the empty entry.
// ----------------------------------------------------------------------------
module tkh_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clr,
  input  logic                      we,
  input  logic [tkh_pkg::IDX_W-1:0] waddr,
  input  tkh_pkg::entry_t           wdata,
  input  logic [tkh_pkg::IDX_W-1:0] raddr_a,
  input  logic [tkh_pkg::IDX_W-1:0] raddr_b,
  output tkh_pkg::entry_t           rdata_a,
  output tkh_pkg::entry_t           rdata_b
);
  import tkh_pkg::*;

  localparam entry_t EMPTY_ENTRY = '{score: EMPTY_SCORE, head: 64'd0, tail: 32'd0};

  entry_t                 mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= valid[raddr_a] ? mem[raddr_a] : EMPTY_ENTRY;
    rdata_b <= valid[raddr_b] ? mem[raddr_b] : EMPTY_ENTRY;
  end

endmodule

>>> sv/tkh_sift_cmp.sv
// ----------------------------------------------------------------------------
// tkh_sift_cmp
// Child compare unit of the sift-down: picks the larger in-range child,
// left on ties, and moves only when it is strictly above the moving score.
// ----------------------------------------------------------------------------
module tkh_sift_cmp (
  input  logic [31:0]       cand_score,
  input  logic [31:0]       left_score,
  input  logic [31:0]       right_score,
  input  logic              left_ok,
  input  logic              right_ok,
  output tkh_pkg::cmp_sel_t sel
);
  import tkh_pkg::*;

  logic        take_left;
  logic [31:0] big_score;

  always_comb begin
    take_left      = left_ok && (left_score > cand_score);
    big_score      = take_left ? left_score : cand_score;
    sel.take_right = right_ok && (right_score > big_score);
    sel.move       = take_left || sel.take_right;
  end

endmodule

>>> sv/top_k_min_heap_selector.sv
// ----------------------------------------------------------------------------
// top_k_min_heap_selector
// Keeps the K smallest scores seen with their 96-bit ids in a max-heap.
// ----------------------------------------------------------------------------
// cand carries one item: mode, id and score. An insert is taken only in
// idle; the root is read, then one heap level is compared per cycle by the
// shared child compare unit. A reject shows its result item after the
// accept and the root check; an accept after the accept, the root check
// and a compare per heap level visited, the last of which writes the
// candidate into its final slot. A registered memory read comes ahead of
// each compare. A dump gives K result items, each by a memory read and an
// output step, last set on the final one. A clear gives no result;
// mode 3 is dropped.
// res holds its item in an output register until it is taken; while the
// receiver stalls the block waits and cand stays not ready.
// cfg writes K (active_entries) at any time; it is always ready. A value of
// 0 acts as 1, above the heap depth as the depth.
// Reset empties the heap at once (all entries read as score all ones,
// id 0) and sets K to 10.
// ----------------------------------------------------------------------------
module top_k_min_heap_selector (
  input  logic  clk,
  input  logic  rst,
  tkh_in_if.sink    cand,
  tkh_out_if.source res,
  tkh_cfg_if.sink   cfg
);
  import tkh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROOT  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_DREAD = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state, state_next;
  logic [CFG_W-1:0] active_entries;
  logic [K_W-1:0]   k;
  entry_t           cand_entry;
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] jcnt, jcnt_next;
  logic             dumping, dumping_next;
  out_item_t        out_item, out_item_next;
  logic             out_valid, out_valid_next;

  logic             st_clr, st_we;
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  entry_t           wdata, rdata_a, rdata_b;
  cmp_sel_t         sel;

  logic [CH_W-1:0]  left_idx, right_idx, child_idx, cl_idx;
  logic             accept_in;

  assign cfg.ready = 1'b1;
  assign cand.ready = (state == S_IDLE);
  assign accept_in  = cand.valid && cand.ready;
  assign res.valid  = out_valid;
  assign res.item   = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= K_RESET;
    end else if (cfg.valid) begin
      active_entries <= cfg.data;
    end
  end

  always_comb begin
    if (active_entries == '0) begin
      k = K_W'(1);
    end else if (int'(active_entries) > MAX_ENTRIES) begin
      k = K_W'(MAX_ENTRIES);
    end else begin
      k = K_W'(active_entries);
    end
  end

  // children of the current slot and of the slot moved into
  always_comb begin
    left_idx  = {1'b0, pos, 1'b1};
    right_idx = left_idx + CH_W'(1);
    child_idx = sel.take_right ? right_idx : left_idx;
    cl_idx    = {child_idx[IDX_W:0], 1'b1};
  end

  tkh_sift_cmp u_cmp (
    .cand_score  (cand_entry.score),
    .left_score  (rdata_a.score),
    .right_score (rdata_b.score),
    .left_ok     (left_idx < CH_W'(k)),
    .right_ok    (right_idx < CH_W'(k)),
    .sel         (sel)
  );

  tkh_store u_store (
    .clk     (clk),
    .rst     (rst),
    .clr     (st_clr),
    .we      (st_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    jcnt_next      = jcnt;
    dumping_next   = dumping;
    out_item_next  = out_item;
    out_valid_next = out_valid;
    st_clr         = 1'b0;
    st_we          = 1'b0;
    waddr          = pos;
    wdata          = cand_entry;
    raddr_a        = '0;
    raddr_b        = '0;
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          case (cand.item.mode)
            MODE_INSERT: begin
              state_next = S_ROOT;
            end
            MODE_CLEAR: begin
              st_clr = 1'b1;
            end
            MODE_DUMP: begin
              jcnt_next    = '0;
              dumping_next = 1'b1;
              state_next   = S_DREAD;
            end
            default: begin
            end
          endcase
        end
      end
      S_ROOT: begin
        if (rdata_a.score < cand_entry.score) begin
          out_item_next  = '{value: rdata_a.score, entry_head: 64'd0,
                            entry_tail: 32'd0, accepted: 1'b0, last: 1'b1};
          out_valid_next = 1'b1;
          dumping_next   = 1'b0;
          state_next     = S_OUT;
        end else begin
          pos_next   = '0;
          raddr_a    = IDX_W'(1);
          raddr_b    = IDX_W'(2);
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        st_we = 1'b1;
        if (sel.move) begin
          // child moves up into this slot, candidate goes one level down
          wdata      = sel.take_right ? rdata_b : rdata_a;
          pos_next   = child_idx[IDX_W-1:0];
          raddr_a    = cl_idx[IDX_W-1:0];
          raddr_b    = cl_idx[IDX_W-1:0] + IDX_W'(1);
        end else begin
          out_item_next  = '{value: cand_entry.score, entry_head: 64'd0,
                            entry_tail: 32'd0, accepted: 1'b1, last: 1'b1};
          out_valid_next = 1'b1;
          dumping_next   = 1'b0;
          state_next     = S_OUT;
        end
      end
      S_DREAD: begin
        out_item_next  = '{value: rdata_a.score, entry_head: rdata_a.head,
                          entry_tail: rdata_a.tail, accepted: 1'b0,
                          last: (K_W'(jcnt) + K_W'(1)) == k};
        out_valid_next = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        raddr_a = jcnt + IDX_W'(1);
        if (res.ready) begin
          out_valid_next = 1'b0;
          if (dumping && !out_item.last) begin
            jcnt_next  = jcnt + IDX_W'(1);
            state_next = S_DREAD;
          end else begin
            dumping_next = 1'b0;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dumping   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      dumping   <= dumping_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    jcnt     <= jcnt_next;
    out_item <= out_item_next;
    if (accept_in) begin
      cand_entry <= '{score: cand.item.score, head: cand.item.id_head,
                      tail: cand.item.id_tail};
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result item shown outside output state");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (K_W'(pos) < k))
    else $error("sift position beyond active entries");

  a_accept_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.accepted) |-> (out_item.value == cand_entry.score))
    else $error("accepted insert does not return candidate score");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && out_item.last) |=> (state == S_IDLE))
    else $error("block not idle after final result item");

endmodule
